/* src/fqds_pkg.sv */
package fqds_pkg;

  localparam int PosWidth = 32;
  localparam int DivCntW  = $clog2(PosWidth);
  localparam int MaxRun   = 9;

  localparam logic [7:0] OP_WAIT      = 8'h61;
  localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
  localparam logic [7:0] OP_WAIT_PAL  = 8'h63;
  localparam logic [7:0] OP_END       = 8'h66;
  localparam logic [7:0] OP_DATA      = 8'h67;
  localparam logic [3:0] HI_WAIT_N    = 4'h7;
  localparam logic [3:0] HI_WRITE_N   = 4'h8;

  localparam logic [15:0] WaitNtsc = 16'd735;
  localparam logic [15:0] WaitPal  = 16'd882;

  localparam logic [1:0] CfgRoundTo  = 2'd0;
  localparam logic [1:0] CfgFrameCmd = 2'd1;
  localparam logic [1:0] CfgMaxDelay = 2'd2;

  localparam logic [15:0] RoundToReset  = 16'd735;
  localparam logic [7:0]  FrameCmdReset = 8'd98;
  localparam logic [15:0] MaxDelayReset = 16'd65415;

  typedef struct packed {
    logic latch;
    logic decode;
    logic div_step;
    logic mul;
    logic chunk;
    logic test;
    logic send;
  } fqds_cmd_t;

  typedef struct packed {
    logic stopped;
    logic dec_wait;
    logic div_last;
    logic cont;
    logic more;
    logic send_last;
    logic out_free;
  } fqds_status_t;

  // Total length in bytes of a command, opcode included.
  function automatic logic [3:0] cmd_length(logic [7:0] op);
    logic [3:0] len;
    case (op)
      8'h50, 8'h94:        len = 4'd2;
      OP_WAIT:             len = 4'd3;
      OP_DATA:             len = 4'd7;
      8'h68:               len = 4'd12;
      8'h90, 8'h91, 8'h95: len = 4'd5;
      8'h92:               len = 4'd6;
      8'h93:               len = 4'd11;
      default: begin
        case (op[7:4])
          4'h3, 4'h4: len = 4'd2;
          4'h5, 4'hA, 4'hB: len = 4'd3;
          4'hC, 4'hD: len = 4'd4;
          4'hE, 4'hF: len = 4'd5;
          default: len = 4'd1;
        endcase
      end
    endcase
    return len;
  endfunction

endpackage

/* src/fqds_ctrl.sv */
module fqds_ctrl
  import fqds_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  fqds_status_t sts,
  output fqds_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_PEEK   = 8'b0001_0000,
    S_CHUNK  = 8'b0010_0000,
    S_TEST   = 8'b0100_0000,
    S_SEND   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.stopped) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.decode = 1'b1;
          state_next = sts.dec_wait ? S_DIV : S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_PEEK;
      end
      S_PEEK: begin
        state_next = sts.cont ? S_CHUNK : S_IDLE;
      end
      S_CHUNK: begin
        cmd.chunk  = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        // Looking one chunk ahead tells whether this chunk closes the run.
        cmd.test   = 1'b1;
        state_next = S_SEND;
      end
      S_SEND: begin
        if (sts.out_free) begin
          cmd.send = 1'b1;
          if (sts.send_last) state_next = sts.more ? S_CHUNK : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* src/fqds_datapath.sv */
module fqds_datapath
  import fqds_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic [7:0]   in_byte,
  input  logic         out_stall,
  output logic         out_valid,
  output logic [7:0]   out_byte,
  output logic         last_of_run,
  output logic         stream_ended,
  input  fqds_cmd_t    cmd,
  output fqds_status_t sts
);

  logic [15:0] round_to, max_delay;
  logic [7:0]  frame_cmd;
  logic [15:0] r_eff, md_eff;

  logic [7:0]  in_reg;
  logic [7:0]  opcode, opcode_next;
  logic [31:0] remaining, remaining_next;
  logic [3:0]  byte_index, index_next;
  logic [31:0] gather, gather_next;
  logic        stopped, stopped_next;
  logic [15:0] add_amt;
  logic        dec_wait, dec_put, dec_end;

  logic [PosWidth-1:0] src_pos, src_next, emit_pos, target, quo, qp;
  logic [15:0]         rem;
  logic [DivCntW-1:0]  dcnt;
  logic [16:0]         trial;
  logic                ge, round_up;
  logic [PosWidth+15:0] prod;

  logic [PosWidth-1:0] gap;
  logic                gap_one, gap_two, frame, cont;
  logic [1:0]          cnt;
  logic [15:0]         dly;
  logic [3:0]          run_cnt;
  logic [7:0]          chunk [3];
  logic [1:0]          chunk_cnt, sidx;
  logic                more, send_last, out_free;

  assign r_eff  = (round_to == 16'd0) ? 16'd1 : round_to;
  assign md_eff = (max_delay == 16'd0) ? 16'd1 : max_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_to  <= RoundToReset;
      frame_cmd <= FrameCmdReset;
      max_delay <= MaxDelayReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CfgRoundTo:  round_to  <= cfg_data;
        CfgFrameCmd: frame_cmd <= cfg_data[7:0];
        CfgMaxDelay: max_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  // Command parsing for the byte held in in_reg.
  always_comb begin
    opcode_next    = opcode;
    remaining_next = remaining;
    index_next     = byte_index;
    gather_next    = gather;
    stopped_next   = stopped;
    add_amt        = '0;
    dec_wait       = 1'b0;
    dec_put        = 1'b0;
    dec_end        = 1'b0;
    if (remaining == 32'd0) begin
      opcode_next    = in_reg;
      index_next     = 4'd1;
      gather_next    = '0;
      remaining_next = 32'(cmd_length(in_reg)) - 32'd1;
      if (in_reg == OP_END) begin
        dec_put      = 1'b1;
        dec_end      = 1'b1;
        stopped_next = 1'b1;
      end else if (in_reg == OP_WAIT_NTSC) begin
        add_amt  = WaitNtsc;
        dec_wait = 1'b1;
      end else if (in_reg == OP_WAIT_PAL) begin
        add_amt  = WaitPal;
        dec_wait = 1'b1;
      end else if (in_reg[7:4] == HI_WAIT_N) begin
        add_amt  = {12'd0, in_reg[3:0]} + 16'd1;
        dec_wait = 1'b1;
      end else if (in_reg != OP_WAIT) begin
        if (in_reg[7:4] == HI_WRITE_N) add_amt = {12'd0, in_reg[3:0]};
        dec_put = 1'b1;
      end
    end else begin
      remaining_next = remaining - 32'd1;
      if (byte_index != 4'hF) index_next = byte_index + 4'd1;
      if (opcode == OP_WAIT) begin
        if (byte_index == 4'd1)      gather_next[7:0]  = in_reg;
        else if (byte_index == 4'd2) gather_next[15:8] = in_reg;
        if (remaining == 32'd1) begin
          add_amt  = gather_next[15:0];
          dec_wait = 1'b1;
        end
      end else begin
        if (opcode == OP_DATA) begin
          case (byte_index)
            4'd3: gather_next[7:0]   = in_reg;
            4'd4: gather_next[15:8]  = in_reg;
            4'd5: gather_next[23:16] = in_reg;
            4'd6: begin
              gather_next[31:24] = in_reg;
              remaining_next     = {1'b0, gather_next[30:0]};
            end
            default: ;
          endcase
        end
        dec_put = 1'b1;
      end
    end
  end

  assign src_next = src_pos + PosWidth'(add_amt);

  // Restoring divider, one quotient bit per step.
  assign trial    = {rem, quo[PosWidth-1]};
  assign ge       = trial >= {1'b0, r_eff};
  assign round_up = {rem, 1'b0} >= {1'b0, r_eff};
  assign qp       = quo + PosWidth'(round_up);
  assign prod     = (PosWidth+16)'(qp) * (PosWidth+16)'(r_eff);

  // Next replacement wait toward the rounded target.
  assign gap     = target - emit_pos;
  assign gap_one = gap == PosWidth'(r_eff);
  assign gap_two = gap == PosWidth'({r_eff, 1'b0});
  assign frame   = (frame_cmd != 8'd0) && (gap_one || gap_two);
  assign cnt     = frame ? (gap_one ? 2'd1 : 2'd2) : 2'd3;
  assign cont    = (emit_pos < target) && ((5'(run_cnt) + 5'(cnt)) <= 5'(MaxRun));
  assign dly     = (gap < PosWidth'(md_eff)) ? gap[15:0] : md_eff;

  assign send_last = (sidx + 2'd1) == chunk_cnt;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      opcode     <= '0;
      remaining  <= '0;
      byte_index <= '0;
      gather     <= '0;
      stopped    <= 1'b0;
      src_pos    <= '0;
      emit_pos   <= '0;
      run_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.decode) begin
        opcode     <= opcode_next;
        remaining  <= remaining_next;
        byte_index <= index_next;
        gather     <= gather_next;
        stopped    <= stopped_next;
        src_pos    <= src_next;
        run_cnt    <= '0;
      end
      if (cmd.chunk) begin
        emit_pos <= frame ? target : emit_pos + PosWidth'(dly);
        run_cnt  <= run_cnt + 4'(cnt);
      end
      if ((cmd.decode && dec_put) || cmd.send) out_valid <= 1'b1;
      else if (!out_stall)                   out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) in_reg <= in_byte;
    if (cmd.decode && dec_wait) begin
      quo  <= src_next;
      rem  <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      rem  <= ge ? 16'(trial - {1'b0, r_eff}) : trial[15:0];
      quo  <= {quo[PosWidth-2:0], ge};
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.mul) target <= prod[PosWidth-1:0];
    if (cmd.chunk) begin
      chunk_cnt <= cnt;
      sidx      <= '0;
      if (frame) begin
        chunk[0] <= frame_cmd;
        chunk[1] <= frame_cmd;
        chunk[2] <= frame_cmd;
      end else begin
        chunk[0] <= OP_WAIT;
        chunk[1] <= dly[7:0];
        chunk[2] <= dly[15:8];
      end
    end
    if (cmd.test) more <= cont;
    if (cmd.decode && dec_put) begin
      out_byte     <= in_reg;
      last_of_run  <= 1'b1;
      stream_ended <= dec_end;
    end else if (cmd.send) begin
      out_byte     <= chunk[sidx];
      last_of_run  <= send_last && !more;
      stream_ended <= 1'b0;
      sidx         <= sidx + 2'd1;
    end
  end

  always_comb begin
    sts           = '0;
    sts.stopped   = stopped;
    sts.dec_wait  = dec_wait;
    sts.div_last  = dcnt == DivCntW'(PosWidth - 1);
    sts.cont      = cont;
    sts.more      = more;
    sts.send_last = send_last;
    sts.out_free  = out_free;
  end

`ifndef SYNTHESIS
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_cnt <= 4'(MaxRun))
    else $error("more bytes planned for one input than allowed");

  a_emit_only_on_chunk: assert property (@(posedge clk) disable iff (rst)
    !cmd.chunk |=> $stable(emit_pos))
    else $error("emitted position moved outside a chunk step");

  a_end_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_ended |-> out_byte == OP_END && last_of_run)
    else $error("end flag on a byte that is not a final end command");
`endif

endmodule

/* src/frame_quantize_delay_stream.sv */
// A pass-through byte is registered in in_reg, then passed to out_byte once the output is free.
// The input stalls until the controller is back in idle, so a new byte waits for the last.
// A wait command adds a divider pass, a multiply step and a check step, then chunk and test
// setup steps per emitted wait chunk plus a send step per emitted byte.
// Reset (synchronous, rst high) clears the parser, both sample positions and out_valid,
// and loads round_to 735, frame_cmd 98 and max_delay 65415.
module frame_quantize_delay_stream
  import fqds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        stream_ended
);

  fqds_cmd_t    cmd;
  fqds_status_t sts;

  fqds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fqds_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_byte      (in_byte),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .stream_ended (stream_ended),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
